FILE: hdl/cruijff_function_eval_assert.svh
// Assertion macros used by the port checker of the Cruijff evaluator.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef CRUIJFF_FUNCTION_EVAL_ASSERT_SVH
`define CRUIJFF_FUNCTION_EVAL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cfe_pkg.sv
// Shared types and constants of the Cruijff peak shape evaluator.
// Depends on nothing; used by every module of the block.
package cfe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_TABLE = 14;
	localparam int DIV_BITS = 21;
	localparam int NUM_W = 48;
	localparam int DEN_W = 34;
	localparam int FRONT_STAGES = 5;
	localparam int EXP_FIXED_STAGES = 4;
	localparam int FIXED_LATENCY = FRONT_STAGES + DIV_BITS + EXP_FIXED_STAGES;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam logic [29:0] ROOT_FACTORS [MAX_TABLE] = '{
		30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
		30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
		30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135,
		30'd1073650976, 30'd1073696399
	};

	typedef enum logic [2:0] {
		CFG_PEAK_MEAN   = 3'd0,
		CFG_LEFT_WIDTH  = 3'd1,
		CFG_RIGHT_WIDTH = 3'd2,
		CFG_TAIL_FACTOR = 3'd3,
		CFG_PEAK_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic one;
		logic zero;
	} cfe_side_t;

endpackage

FILE: hdl/cfe_front.sv
// Front end: distance to the mean, its square and the Cruijff denominator.
// Depends on cfe_pkg; feeds cfe_divider.
module cfe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [15:0]                  sample_x,
	input  logic [15:0]                  peak_mean,
	input  logic [15:0]                  left_width,
	input  logic [15:0]                  right_width,
	input  logic [15:0]                  tail_factor,
	output cfe_pkg::cfe_side_t           side_out,
	output logic [cfe_pkg::NUM_W-1:0]    num_out,
	output logic [cfe_pkg::DEN_W-1:0]    den_out
);

	cfe_pkg::cfe_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic        left_s1, left_s2;
	logic [15:0] diff_s1;
	logic [31:0] d_s2, d_s3, d_s4;
	logic [31:0] w2_s2;
	logic [32:0] twow_s3;
	logic [31:0] tail_s3;
	logic [cfe_pkg::DEN_W-1:0] den_s4, den_s5;
	logic [cfe_pkg::NUM_W-1:0] num_s5;
	logic        left_c, eq_c;
	logic [15:0] diff_c, wsel_c;
	logic [47:0] tail_prod_c;
	logic        zero_den_c, sat_c;

	assign left_c = sample_x < peak_mean;
	assign eq_c = sample_x == peak_mean;
	assign diff_c = left_c ? (peak_mean - sample_x) : (sample_x - peak_mean);
	assign wsel_c = left_s1 ? left_width : right_width;
	assign tail_prod_c = 48'(tail_factor) * 48'(d_s2);
	assign zero_den_c = den_s4 == '0;
	assign sat_c = 39'(d_s4) >= {den_s4, 5'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else begin
			side_s1 <= '{valid: start, one: eq_c, zero: 1'b0};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= '{valid: side_s4.valid, one: side_s4.one | zero_den_c, zero: sat_c};
		end
	end

	always_ff @(posedge clk) begin
		left_s1 <= left_c;
		diff_s1 <= diff_c;
		left_s2 <= left_s1;
		d_s2 <= 32'(diff_s1) * 32'(diff_s1);
		w2_s2 <= 32'(wsel_c) * 32'(wsel_c);
		d_s3 <= d_s2;
		twow_s3 <= {w2_s2, 1'b0};
		tail_s3 <= left_s2 ? tail_prod_c[47:16] : 32'd0;
		d_s4 <= d_s3;
		den_s4 <= cfe_pkg::DEN_W'(twow_s3) + cfe_pkg::DEN_W'(tail_s3);
		den_s5 <= den_s4;
		num_s5 <= {d_s4, 16'b0};
	end

	assign side_out = side_s5;
	assign num_out = num_s5;
	assign den_out = den_s5;

endmodule

FILE: hdl/cfe_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cfe_pkg; fed by cfe_front, feeds cfe_exp.
module cfe_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfe_pkg::cfe_side_t             side_in,
	input  logic [cfe_pkg::NUM_W-1:0]      num_in,
	input  logic [cfe_pkg::DEN_W-1:0]      den_in,
	output cfe_pkg::cfe_side_t             side_out,
	output logic [cfe_pkg::DIV_BITS-1:0]   quo_out
);

	localparam int CMP_W = cfe_pkg::DEN_W + cfe_pkg::DIV_BITS;

	cfe_pkg::cfe_side_t                side_s [cfe_pkg::DIV_BITS+1];
	logic [cfe_pkg::NUM_W-1:0]         rem_s  [cfe_pkg::DIV_BITS+1];
	logic [cfe_pkg::DEN_W-1:0]         den_s  [cfe_pkg::DIV_BITS+1];
	logic [cfe_pkg::DIV_BITS-1:0]      quo_s  [cfe_pkg::DIV_BITS+1];

	assign side_s[0] = side_in;
	assign rem_s[0] = num_in;
	assign den_s[0] = den_in;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < cfe_pkg::DIV_BITS; k++) begin : g_stage
		localparam int BIT = cfe_pkg::DIV_BITS - 1 - k;
		logic [CMP_W-1:0] shifted_c;
		logic             take_c;

		assign shifted_c = CMP_W'(den_s[k]) << BIT;
		assign take_c = CMP_W'(rem_s[k]) >= shifted_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else begin
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take_c ? cfe_pkg::NUM_W'(CMP_W'(rem_s[k]) - shifted_c) : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_s[k] | (cfe_pkg::DIV_BITS'(take_c) << BIT);
		end
	end

	assign side_out = side_s[cfe_pkg::DIV_BITS];
	assign quo_out = quo_s[cfe_pkg::DIV_BITS];

endmodule

FILE: hdl/cfe_exp.sv
// Base-2 exponential by a chain of root factors, scaled by the amplitude.
// Depends on cfe_pkg; fed by cfe_divider, drives the result ports.
module cfe_exp #(
	parameter int EXP_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfe_pkg::cfe_side_t             side_in,
	input  logic [cfe_pkg::DIV_BITS-1:0]   quo_in,
	input  logic [15:0]                    peak_height,
	output logic                           done,
	output logic [23:0]                    shape_value
);

	cfe_pkg::cfe_side_t side_e1, side_sh, side_out_q;
	cfe_pkg::cfe_side_t side_r [EXP_TABLE_BITS+1];
	logic [21:0] u_e1;
	logic [4:0]  whole_r [EXP_TABLE_BITS+1];
	logic [15:0] frac_r  [EXP_TABLE_BITS+1];
	logic [30:0] acc_r   [EXP_TABLE_BITS+1];
	logic [30:0] mant_sh;
	logic        done_q;
	logic [23:0] shape_q;
	logic [51:0] u_prod_c;
	logic [46:0] amp_prod_c;
	logic [23:0] final_c;

	assign u_prod_c = 52'(quo_in) * 52'(cfe_pkg::LOG2E_Q30);
	assign amp_prod_c = 47'(peak_height) * 47'(mant_sh);
	assign final_c = side_sh.one ? {peak_height, 8'b0} :
		side_sh.zero ? 24'd0 : amp_prod_c[45:22];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_e1 <= '0;
			side_r[0] <= '0;
			side_sh <= '0;
			done_q <= 1'b0;
			shape_q <= '0;
		end else begin
			side_e1 <= side_in;
			side_r[0] <= '{valid: side_e1.valid, one: side_e1.one,
				zero: side_e1.zero | u_e1[21]};
			side_sh <= side_r[EXP_TABLE_BITS];
			done_q <= side_sh.valid;
			shape_q <= side_sh.valid ? final_c : 24'd0;
		end
	end

	always_ff @(posedge clk) begin
		u_e1 <= u_prod_c[51:30];
		whole_r[0] <= u_e1[20:16];
		frac_r[0] <= u_e1[15:0];
		acc_r[0] <= cfe_pkg::ONE_Q30;
		mant_sh <= acc_r[EXP_TABLE_BITS] >> whole_r[EXP_TABLE_BITS];
	end

	for (genvar j = 1; j <= EXP_TABLE_BITS; j++) begin : g_root
		logic [60:0] prod_c;

		assign prod_c = 61'(acc_r[j-1]) * 61'(cfe_pkg::ROOT_FACTORS[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_r[j] <= '0;
			end else begin
				side_r[j] <= side_r[j-1];
			end
		end

		always_ff @(posedge clk) begin
			whole_r[j] <= whole_r[j-1];
			frac_r[j] <= frac_r[j-1];
			acc_r[j] <= frac_r[j-1][cfe_pkg::FRAC_BITS-j] ? prod_c[60:30] : acc_r[j-1];
		end
	end

	assign done = done_q;
	assign shape_value = shape_q;

endmodule

FILE: hdl/cruijff_function_eval.sv
// Top level of the Cruijff peak shape evaluator: configuration and pipeline.
// Depends on cfe_pkg, cfe_front, cfe_divider and cfe_exp.
//
//   channel   ports                           handshake
//   input     start, busy, sample_x           taken when start is high and busy low
//   result    done, shape_value               one cycle, marked by done
//   config    cfg_we, cfg_index, cfg_data     written when cfg_we is high
//
// One transaction enters every cycle; busy is always low.
// Each result passes, after its transaction is taken, through the registered stages:
// five front stages, one stage per quotient bit of the 21-bit divider,
// one stage per root factor and four stages around the exponential.
// Reset clears all valid bits and restores the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module cruijff_function_eval #(
	parameter int EXP_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] sample_x,
	output logic        done,
	output logic [23:0] shape_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] peak_mean_q, left_width_q, right_width_q, tail_factor_q, peak_height_q;
	cfe_pkg::cfe_side_t side_front, side_div;
	logic [cfe_pkg::NUM_W-1:0] num_front;
	logic [cfe_pkg::DEN_W-1:0] den_front;
	logic [cfe_pkg::DIV_BITS-1:0] quo_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_mean_q <= 16'd6554;
			left_width_q <= 16'd6554;
			right_width_q <= 16'd6554;
			tail_factor_q <= 16'd0;
			peak_height_q <= 16'd10;
		end else if (cfg_we) begin
			unique case (cfe_pkg::cfg_reg_t'(cfg_index))
				cfe_pkg::CFG_PEAK_MEAN: peak_mean_q <= cfg_data;
				cfe_pkg::CFG_LEFT_WIDTH: left_width_q <= cfg_data;
				cfe_pkg::CFG_RIGHT_WIDTH: right_width_q <= cfg_data;
				cfe_pkg::CFG_TAIL_FACTOR: tail_factor_q <= cfg_data;
				cfe_pkg::CFG_PEAK_HEIGHT: peak_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	cfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.sample_x    (sample_x),
		.peak_mean   (peak_mean_q),
		.left_width  (left_width_q),
		.right_width (right_width_q),
		.tail_factor (tail_factor_q),
		.side_out    (side_front),
		.num_out     (num_front),
		.den_out     (den_front)
	);

	cfe_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_front),
		.num_in   (num_front),
		.den_in   (den_front),
		.side_out (side_div),
		.quo_out  (quo_div)
	);

	cfe_exp #(
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_exp (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_in     (side_div),
		.quo_in      (quo_div),
		.peak_height (peak_height_q),
		.done        (done),
		.shape_value (shape_value)
	);

endmodule

FILE: hdl/cfe_port_checker.sv
// Port-level assertions of the Cruijff evaluator and their bind to the top level.
// Depends on cfe_pkg and cruijff_function_eval_assert.svh.
`include "cruijff_function_eval_assert.svh"

module cfe_port_checker #(
	parameter int EXP_TABLE_BITS = 10
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [23:0] shape_value
);

	localparam int LAT = cfe_pkg::FIXED_LATENCY + EXP_TABLE_BITS;
	localparam int CNT_W = $clog2(LAT + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             primed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CNT_W'(LAT)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign primed = cnt_q == CNT_W'(LAT);

	`CFE_ASSERT_NOW(a_fixed_latency, primed, done == $past(start, LAT), "result strobe does not match a transaction taken at the fixed latency")
	`CFE_ASSERT_NOW(a_idle_output, !done, shape_value == 24'd0, "result port not cleared between results")
	`CFE_ASSERT_NOW(a_done_has_start, done, $past(start, LAT), "result without a matching transaction")
	`CFE_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind cruijff_function_eval cfe_port_checker #(
	.EXP_TABLE_BITS (EXP_TABLE_BITS)
) u_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.shape_value (shape_value)
);

FILE: verif/tb_top.sv
// Self-checking testbench of the Cruijff peak shape evaluator cruijff_function_eval.
// Depends on cfe_pkg and the block; a scoreboard class predicts each shape value.
`timescale 1ns / 1ps

module tb_top;

	class shape_scoreboard;
		logic [15:0] mean_r, lw_r, rw_r, alpha_r, amp_r;
		logic [23:0] pending[$];
		int mismatches;

		function new();
			mean_r = 16'd6554;
			lw_r = 16'd6554;
			rw_r = 16'd6554;
			alpha_r = 16'd0;
			amp_r = 16'd10;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				cfe_pkg::CFG_PEAK_MEAN:   mean_r = val;
				cfe_pkg::CFG_LEFT_WIDTH:  lw_r = val;
				cfe_pkg::CFG_RIGHT_WIDTH: rw_r = val;
				cfe_pkg::CFG_TAIL_FACTOR: alpha_r = val;
				cfe_pkg::CFG_PEAK_HEIGHT: amp_r = val;
				default: ;
			endcase
		endfunction

		function logic [23:0] shape_of(logic [15:0] x);
			logic [63:0] diff, d, denom, t, u, acc, whole, frac, res;
			if (x == mean_r)
				return {amp_r, 8'd0};
			diff = (x > mean_r) ? 64'(x - mean_r) : 64'(mean_r - x);
			d = diff * diff;
			if (x < mean_r)
				denom = 2 * 64'(lw_r) * 64'(lw_r) + ((64'(alpha_r) * d) >> 16);
			else
				denom = 2 * 64'(rw_r) * 64'(rw_r);
			if (denom == 0)
				return {amp_r, 8'd0};
			t = (d << 16) / denom;
			if (t >= (64'd32 << 16))
				return 24'd0;
			u = (t * 64'(cfe_pkg::LOG2E_Q30)) >> 30;
			whole = u >> 16;
			frac = u & 64'hFFFF;
			if (whole >= 32)
				return 24'd0;
			acc = 64'(cfe_pkg::ONE_Q30);
			for (int i = 1; i <= 10; i++) begin
				if ((frac >> (16 - i)) & 64'd1)
					acc = (acc * 64'(cfe_pkg::ROOT_FACTORS[i - 1])) >> 30;
			end
			acc = acc >> whole;
			res = (64'(amp_r) * acc) >> 22;
			return res[23:0];
		endfunction

		function void note_sample(logic [15:0] x);
			pending = {pending, shape_of(x)};
		endfunction

		function void check_shape(logic [23:0] got);
			logic [23:0] want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result shape_value=%0d", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: shape_value expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [15:0] sample_x = 16'd0;
	logic done;
	logic [23:0] shape_value;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;

	shape_scoreboard sb = new();

	cruijff_function_eval DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample_x(sample_x),
		.done(done), .shape_value(shape_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_sample(sample_x);
			if (done)
				sb.check_shape(shape_value);
		end
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	task automatic send_sample(logic [15:0] x);
		logic b;
		cfg_we <= 1'b0;
		start <= 1'b1;
		sample_x <= x;
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b)
				break;
		end
	endtask

	task automatic idle_gap();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			n = 0;
		else if (r < 95)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 16));
			3: return 16'($urandom_range(100, 8000));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		int v;
		int span;
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom);
		span = 4 * ((sb.lw_r > sb.rw_r) ? int'(sb.lw_r) : int'(sb.rw_r)) + 4;
		if (span > 65535)
			span = 65535;
		v = int'(sb.mean_r) + $urandom_range(0, 2 * span) - span;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register defaults, field extremes, sample at the mean.
		send_sample(16'd0);
		send_sample(16'hFFFF);
		send_sample(16'd6554);
		send_sample(16'd6553);
		send_sample(16'd6555);
		send_sample(16'd8000);
		send_sample(16'd3000);
		drain();
		// Zero widths: zero denominator on both sides.
		write_reg(cfe_pkg::CFG_LEFT_WIDTH, 16'd0);
		write_reg(cfe_pkg::CFG_RIGHT_WIDTH, 16'd0);
		write_reg(cfe_pkg::CFG_PEAK_HEIGHT, 16'hFFFF);
		send_sample(16'd0);
		send_sample(16'hFFFF);
		drain();
		// Tail term active, tiny widths give large exponents.
		write_reg(cfe_pkg::CFG_TAIL_FACTOR, 16'hFFFF);
		write_reg(cfe_pkg::CFG_RIGHT_WIDTH, 16'd1);
		write_reg(cfe_pkg::CFG_PEAK_MEAN, 16'h8000);
		write_reg(3'd5, 16'h5A5A);
		write_reg(3'd7, 16'hA5A5);
		send_sample(16'd0);
		send_sample(16'h7FFF);
		send_sample(16'h8001);
		send_sample(16'h8002);
		send_sample(16'hFFFF);
		drain();
		write_reg(cfe_pkg::CFG_LEFT_WIDTH, 16'hFFFF);
		write_reg(cfe_pkg::CFG_RIGHT_WIDTH, 16'hFFFF);
		write_reg(cfe_pkg::CFG_PEAK_HEIGHT, 16'd0);
		send_sample(16'd0);
		send_sample(16'hFFFF);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			for (int r = 0; r < 5; r++)
				write_reg(3'(r), pick_value());
			if ($urandom_range(0, 2) == 0)
				write_reg(3'($urandom_range(5, 7)), 16'($urandom));
			for (int k = 0; k < 125; k++) begin
				send_sample(pick_sample());
				idle_gap();
			end
			drain();
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: cruijff_function_eval.f
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_front.sv
hdl/cfe_divider.sv
hdl/cfe_exp.sv
hdl/cruijff_function_eval.sv
hdl/cfe_port_checker.sv
verif/tb_top.sv
